/* rtl/assert_macros.svh */
// Assertion macros used by the gate top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational implication checked at every clock edge outside reset.
`define ENG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ENG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/engate_pkg.sv */
// Types, constants and register map of the envelope noise gate.
package engate_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    // Q16 arithmetic: serial units walk over Q_STEPS multiplier bits
    localparam int Q_FRAC  = 16;
    localparam int Q_STEPS = Q_FRAC + 1;
    localparam logic [Q_STEPS-1:0] Q_ONE = {1'b1, {Q_FRAC{1'b0}}};

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int THR_W      = 16;
    localparam int COEF_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_GATE_THRESHOLD = 3'd0,
        IDX_ATTACK_COEF    = 3'd1,
        IDX_RELEASE_COEF   = 3'd2,
        IDX_ATTEN_GAIN     = 3'd3,
        IDX_WET_MIX        = 3'd4,
        IDX_STEREO_MODE    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]   gate_threshold;
        logic [COEF_W-1:0]  attack_coef;
        logic [COEF_W-1:0]  release_coef;
        logic [Q_STEPS-1:0] atten_gain;
        logic [Q_STEPS-1:0] wet_mix;
        logic               stereo_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gate_threshold: 16'd1036,
        attack_coef:    16'd65000,
        release_coef:   16'd65530,
        atten_gain:     17'd0,
        wet_mix:        17'd65536,
        stereo_mode:    1'b1
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ENV,
        ST_SCALE,
        ST_DONE
    } t_state;

endpackage

/* rtl/engate_if.sv */
// Channel interfaces: sample requests, result requests and register writes.
interface engate_in_if import engate_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

interface engate_out_if import engate_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          gate_closed;
    logic        [SAMPLE_BITS-1:0] envelope_level;

    modport source (output valid, output out_left, output out_right, output gate_closed,
                    output envelope_level, input ready);
    modport sink   (input valid, input out_left, input out_right, input gate_closed,
                    input envelope_level, output ready);
endinterface

interface engate_cfg_if import engate_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/engate_smul.sv */
// Bit-serial shift-add unit: floor((a0*b0 + a1*b1) / 2^16), one multiplier bit a cycle.
module engate_smul import engate_pkg::*; #(
    parameter int A_W = SAMPLE_BITS_DEF + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [A_W-1:0] i_a0,
    input  logic signed [A_W-1:0] i_a1,
    input  logic [Q_STEPS-1:0]    i_b0,
    input  logic [Q_STEPS-1:0]    i_b1,
    output logic                  o_done,
    output logic signed [A_W-1:0] o_res
);

    localparam int ACC_W = A_W + 2;
    localparam int CNT_W = $clog2(Q_STEPS);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [A_W-1:0]   r_a0;
    logic signed [A_W-1:0]   r_a1;
    logic [Q_STEPS-1:0]      r_b0;
    logic [Q_STEPS-1:0]      r_b1;

    logic signed [ACC_W-1:0] w_add0;
    logic signed [ACC_W-1:0] w_add1;
    logic signed [ACC_W-1:0] w_sum;
    logic                    w_last;

    assign w_add0 = r_b0[0] ? {{2{r_a0[A_W-1]}}, r_a0} : '0;
    assign w_add1 = r_b1[0] ? {{2{r_a1[A_W-1]}}, r_a1} : '0;
    assign w_sum  = r_acc + w_add0 + w_add1;
    assign w_last = (r_cnt == CNT_W'(Q_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Low bits drop out as they settle; the top bit step keeps its weight.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a0  <= i_a0;
            r_a1  <= i_a1;
            r_b0  <= i_b0;
            r_b1  <= i_b1;
        end else if (r_busy) begin
            r_b0 <= r_b0 >> 1;
            r_b1 <= r_b1 >> 1;
            if (w_last) begin
                r_acc <= w_sum;
            end else begin
                r_acc <= w_sum >>> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = $signed(r_acc[A_W-1:0]);

endmodule

/* rtl/engate_core.sv */
// Gate sequencer: envelope update, gain and sample scaling on serial units.
module engate_core import engate_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic signed [SAMPLE_BITS-1:0] o_left,
    output logic signed [SAMPLE_BITS-1:0] o_right,
    output logic                          o_closed,
    output logic [SAMPLE_BITS-1:0]        o_env
);

    localparam int W     = SAMPLE_BITS;
    localparam int CMP_W = (W > THR_W) ? W : THR_W;
    localparam int GA_W  = Q_STEPS + 1;

    t_state r_state;
    t_state n_state;

    logic signed [W-1:0] r_left;
    logic signed [W-1:0] r_right;
    logic [W-1:0]        r_env;
    logic signed [W-1:0] r_out_left;
    logic signed [W-1:0] r_out_right;
    logic                r_closed;

    logic [W-1:0]         w_abs_l;
    logic [W-1:0]         w_abs_r;
    logic [W-1:0]         w_mag;
    logic [Q_STEPS-1:0]   w_coef;
    logic [Q_STEPS-1:0]   w_coef_rest;
    logic [Q_STEPS-1:0]   w_att;
    logic [Q_STEPS-1:0]   w_wet;
    logic [Q_STEPS-1:0]   w_gain;
    logic [W-1:0]         w_env_new;
    logic                 w_below;

    logic                 w_start_env;
    logic                 w_start_scale;

    logic                 w_env_done;
    logic                 w_gain_done;
    logic                 w_scl_l_done;
    logic                 w_scl_r_done;
    logic signed [W:0]    w_env_res;
    logic signed [GA_W-1:0] w_gain_res;
    logic signed [W-1:0]  w_scl_l_res;
    logic signed [W-1:0]  w_scl_r_res;
    logic                 w_stage1_done;
    logic                 w_stage2_done;

    // Magnitudes; the most negative sample wraps to 2^(W-1), which is exact.
    assign w_abs_l = r_left[W-1]  ? $unsigned(-r_left)  : $unsigned(r_left);
    assign w_abs_r = r_right[W-1] ? $unsigned(-r_right) : $unsigned(r_right);
    assign w_mag   = (w_abs_r > w_abs_l) ? w_abs_r : w_abs_l;

    assign w_coef      = (w_mag >= r_env) ? {1'b0, i_cfg.attack_coef}
                                          : {1'b0, i_cfg.release_coef};
    assign w_coef_rest = Q_ONE - w_coef;

    assign w_att  = (i_cfg.atten_gain > Q_ONE) ? Q_ONE : i_cfg.atten_gain;
    assign w_wet  = (i_cfg.wet_mix > Q_ONE) ? Q_ONE : i_cfg.wet_mix;
    assign w_gain = w_gain_res[Q_STEPS-1:0] + (Q_ONE - w_wet);

    assign w_env_new = w_env_res[W-1:0];
    assign w_below   = (CMP_W'(w_env_new) < CMP_W'(i_cfg.gate_threshold));

    assign w_stage1_done = w_env_done && w_gain_done;
    assign w_stage2_done = w_scl_l_done && w_scl_r_done;

    engate_smul #(.A_W(W + 1)) u_env (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_env),
        .i_a0    ($signed({1'b0, r_env})),
        .i_a1    ($signed({1'b0, w_mag})),
        .i_b0    (w_coef),
        .i_b1    (w_coef_rest),
        .o_done  (w_env_done),
        .o_res   (w_env_res)
    );

    engate_smul #(.A_W(GA_W)) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_env),
        .i_a0    ($signed({1'b0, w_att})),
        .i_a1    ('0),
        .i_b0    (w_wet),
        .i_b1    ('0),
        .o_done  (w_gain_done),
        .o_res   (w_gain_res)
    );

    engate_smul #(.A_W(W)) u_scl_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_scale),
        .i_a0    (r_left),
        .i_a1    ('0),
        .i_b0    (w_gain),
        .i_b1    ('0),
        .o_done  (w_scl_l_done),
        .o_res   (w_scl_l_res)
    );

    engate_smul #(.A_W(W)) u_scl_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_scale),
        .i_a0    (r_right),
        .i_a1    ('0),
        .i_b0    (w_gain),
        .i_b1    ('0),
        .o_done  (w_scl_r_done),
        .o_res   (w_scl_r_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_PREP;
            ST_PREP:  n_state = ST_ENV;
            ST_ENV:   if (w_stage1_done) n_state = w_below ? ST_SCALE : ST_DONE;
            ST_SCALE: if (w_stage2_done) n_state = ST_DONE;
            ST_DONE:  if (i_res_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        o_res_valid   = (r_state == ST_DONE);
        w_start_env   = (r_state == ST_PREP);
        w_start_scale = (r_state == ST_ENV) && w_stage1_done && w_below;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_env   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ENV && w_stage1_done) begin
                r_env <= w_env_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_left  <= i_left;
            r_right <= i_cfg.stereo_mode ? i_right : '0;
        end
        if (r_state == ST_ENV && w_stage1_done) begin
            r_closed <= w_below;
            // open gate: samples go out as taken
            if (!w_below) begin
                r_out_left  <= r_left;
                r_out_right <= r_right;
            end
        end
        if (r_state == ST_SCALE && w_stage2_done) begin
            r_out_left  <= w_scl_l_res;
            r_out_right <= w_scl_r_res;
        end
    end

    assign o_left   = r_out_left;
    assign o_right  = r_out_right;
    assign o_closed = r_closed;
    assign o_env    = r_env;

endmodule

/* rtl/envelope_noise_gate.sv */
// Top level of the envelope noise gate: registers, core and output stage.
//
//  channel  | direction | contents
//  i_in     | sink      | sample_left, sample_right
//  o_out    | source    | out_left, out_right, gate_closed, envelope_level
//  i_cfg    | sink      | index, data (register write, always ready)
//
//  A request holds the core for one pass of the serial shift-add units for the envelope
//  and gain and, with the gate closed, a second one for the sample scaling, one
//  multiplier bit a cycle.
//  Reset clears the envelope and loads the register defaults; no clearing pass.
//  A result waits in the output register while the next request is taken;
//  a stalled sink holds the core only once that register is full.
`include "assert_macros.svh"

module envelope_noise_gate import engate_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    engate_in_if.sink     i_in,
    engate_out_if.source  o_out,
    engate_cfg_if.sink    i_cfg
);

    localparam logic [SAMPLE_BITS-1:0] ENV_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_cfg r_cfg;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic                          r_out_closed;
    logic [SAMPLE_BITS-1:0]        r_out_env;

    logic                          w_core_valid;
    logic                          w_core_ready;
    logic signed [SAMPLE_BITS-1:0] w_core_left;
    logic signed [SAMPLE_BITS-1:0] w_core_right;
    logic                          w_core_closed;
    logic [SAMPLE_BITS-1:0]        w_core_env;
    logic                          w_in_acc;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                IDX_GATE_THRESHOLD: r_cfg.gate_threshold <= i_cfg.data[THR_W-1:0];
                IDX_ATTACK_COEF:    r_cfg.attack_coef    <= i_cfg.data[COEF_W-1:0];
                IDX_RELEASE_COEF:   r_cfg.release_coef   <= i_cfg.data[COEF_W-1:0];
                IDX_ATTEN_GAIN:     r_cfg.atten_gain     <= i_cfg.data[Q_STEPS-1:0];
                IDX_WET_MIX:        r_cfg.wet_mix        <= i_cfg.data[Q_STEPS-1:0];
                IDX_STEREO_MODE:    r_cfg.stereo_mode    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    engate_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_left      (i_in.sample_left),
        .i_right     (i_in.sample_right),
        .o_res_valid (w_core_valid),
        .i_res_ready (w_core_ready),
        .o_left      (w_core_left),
        .o_right     (w_core_right),
        .o_closed    (w_core_closed),
        .o_env       (w_core_env)
    );

    assign w_core_ready = !r_out_valid || o_out.ready;
    assign w_in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_core_valid && w_core_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_core_valid && w_core_ready) begin
            r_out_left   <= w_core_left;
            r_out_right  <= w_core_right;
            r_out_closed <= w_core_closed;
            r_out_env    <= w_core_env;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_left       = r_out_left;
    assign o_out.out_right      = r_out_right;
    assign o_out.gate_closed    = r_out_closed;
    assign o_out.envelope_level = r_out_env;

    // The envelope is a floor of a weighted mean, so it never passes the largest magnitude.
    `ENG_ASSERT(a_env_bound, !o_out.valid || (o_out.envelope_level <= ENV_MAX), "envelope above full scale")
    `ENG_ASSERT_NEXT(a_one_in_flight, w_in_acc, !i_in.ready, "second request taken while busy")
    `ENG_ASSERT_NEXT(a_core_holds, w_core_valid && !w_core_ready, w_core_valid, "core result dropped")

endmodule

/* sim/envelope_noise_gate_tb.sv */
// Self-checking testbench of the envelope noise gate: predicts every frame and compares.
module envelope_noise_gate_tb;
    import engate_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int PHASES       = 12;
    localparam int PHASE_FRAMES = 128;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 60;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef enum int {LEVEL_LOUD, LEVEL_QUIET, LEVEL_HUSH, LEVEL_PEAK} t_level;
    typedef enum int {SET_LOWS, SET_HIGHS, SET_RANDOM} t_setting;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 closed;
        logic        [SB-1:0] env;
    } t_gate_frame;

    class GateScoreboard;
        t_cfg          regs;
        logic [SB-1:0] envelope;
        t_gate_frame   awaited[$];
        int            fails;
        int            frames;
        int            results;
        int            closed_frames;
        int            mono_frames;
        int            reg_writes;

        function new();
            regs          = CFG_RESET;
            envelope      = '0;
            fails         = 0;
            frames        = 0;
            results       = 0;
            closed_frames = 0;
            mono_frames   = 0;
            reg_writes    = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            fails++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            reg_writes++;
            case (idx)
                IDX_GATE_THRESHOLD: regs.gate_threshold = value[THR_W-1:0];
                IDX_ATTACK_COEF:    regs.attack_coef    = value[COEF_W-1:0];
                IDX_RELEASE_COEF:   regs.release_coef   = value[COEF_W-1:0];
                IDX_ATTEN_GAIN:     regs.atten_gain     = value[Q_STEPS-1:0];
                IDX_WET_MIX:        regs.wet_mix        = value[Q_STEPS-1:0];
                IDX_STEREO_MODE:    regs.stereo_mode    = value[0];
                default: ;
            endcase
        endfunction

        // envelope update and gate gain for one accepted request
        function void note_frame(logic signed [SB-1:0] left_in, logic signed [SB-1:0] right_in);
            longint      l, r, mag, mag_r, coef, nenv, att, wet, gain, unity;
            t_gate_frame f;
            unity = longint'(Q_ONE);
            l     = longint'(left_in);
            r     = regs.stereo_mode ? longint'(right_in) : 64'sd0;
            mag   = (l < 0) ? -l : l;
            mag_r = (r < 0) ? -r : r;
            if (regs.stereo_mode && mag_r > mag)
                mag = mag_r;
            coef = (mag >= longint'(envelope)) ? longint'(regs.attack_coef)
                                               : longint'(regs.release_coef);
            nenv = (coef * longint'(envelope) + (unity - coef) * mag) >>> 16;
            envelope = nenv[SB-1:0];
            f.closed = (envelope < regs.gate_threshold);
            if (f.closed) begin
                att  = (regs.atten_gain > Q_ONE) ? unity : longint'(regs.atten_gain);
                wet  = (regs.wet_mix > Q_ONE) ? unity : longint'(regs.wet_mix);
                gain = ((att * wet) >>> 16) + unity - wet;
                // arithmetic shift gives floor for negative products too
                l = (l * gain) >>> 16;
                r = (r * gain) >>> 16;
                closed_frames++;
            end
            f.left  = l[SB-1:0];
            f.right = r[SB-1:0];
            f.env   = envelope;
            if (!regs.stereo_mode)
                mono_frames++;
            frames++;
            awaited.push_back(f);
        endfunction

        task check_result(logic signed [SB-1:0] left, logic signed [SB-1:0] right,
                          logic closed, logic [SB-1:0] env);
            t_gate_frame f;
            results++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request waiting", results));
            end else begin
                f = awaited.pop_front();
                if (left !== f.left)
                    report_mismatch($sformatf("result %0d out_left %0d, expected %0d",
                                              results, left, f.left));
                if (right !== f.right)
                    report_mismatch($sformatf("result %0d out_right %0d, expected %0d",
                                              results, right, f.right));
                if (closed !== f.closed)
                    report_mismatch($sformatf("result %0d gate_closed %0b, expected %0b",
                                              results, closed, f.closed));
                if (env !== f.env)
                    report_mismatch($sformatf("result %0d envelope_level %0d, expected %0d",
                                              results, env, f.env));
            end
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    engate_in_if  in_ch ();
    engate_out_if out_ch ();
    engate_cfg_if cfg_ch ();

    envelope_noise_gate dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    GateScoreboard sb;
    bit            in_burst  = 1'b0;
    bit            out_burst = 1'b0;
    int            idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.out_left, out_ch.out_right, out_ch.gate_closed,
                                out_ch.envelope_level);
            if (in_ch.valid && in_ch.ready)
                sb.note_frame(in_ch.sample_left, in_ch.sample_right);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result side: random stalls, with stretches of none
    initial begin : result_sink
        int stall;
        int run_left;
        run_left = 0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (run_left == 0) begin
                out_burst = ($urandom_range(0, 3) == 0);
                run_left  = $urandom_range(1, 60);
            end
            run_left--;
            stall = out_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task send_frame(logic [SB-1:0] left, logic [SB-1:0] right);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_left  <= left;
        in_ch.sample_right <= right;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // one edge first, so a request taken at the current edge is already noted
    task wait_drained();
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // register writes only once every request has come back
    task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        in_ch.valid <= 1'b0;
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] draw_coef();
        case ($urandom_range(0, 4))
            0:       return 17'd0;
            1:       return 17'd65535;
            2:       return CFG_DATA_W'($urandom);
            3:       return CFG_DATA_W'($urandom_range(60000, 65535));
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_gain();
        case ($urandom_range(0, 4))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [SB-1:0] draw_sample(t_level level);
        case (level)
            LEVEL_LOUD:  return SB'($urandom);
            LEVEL_QUIET: return SB'(int'($urandom_range(0, 4095)) - 2048);
            LEVEL_HUSH:  return SB'(int'($urandom_range(0, 31)) - 16);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    3:       return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    task load_settings(t_setting mode);
        case (mode)
            SET_LOWS: begin
                cfg_write(IDX_GATE_THRESHOLD, 17'd0);
                cfg_write(IDX_ATTACK_COEF, 17'd0);
                cfg_write(IDX_RELEASE_COEF, 17'd0);
                cfg_write(IDX_ATTEN_GAIN, 17'd0);
                cfg_write(IDX_WET_MIX, 17'd0);
                cfg_write(IDX_STEREO_MODE, 17'd0);
            end
            SET_HIGHS: begin
                cfg_write(IDX_GATE_THRESHOLD, 17'h1FFFF);
                cfg_write(IDX_ATTACK_COEF, 17'd65535);
                cfg_write(IDX_RELEASE_COEF, 17'd65535);
                cfg_write(IDX_ATTEN_GAIN, 17'h1FFFF);
                cfg_write(IDX_WET_MIX, 17'h1FFFF);
                cfg_write(IDX_STEREO_MODE, 17'h1FFFF);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0:       cfg_write(IDX_GATE_THRESHOLD, 17'd0);
                    1:       cfg_write(IDX_GATE_THRESHOLD, 17'd32768);
                    2:       cfg_write(IDX_GATE_THRESHOLD, CFG_DATA_W'($urandom));
                    default: cfg_write(IDX_GATE_THRESHOLD,
                                       CFG_DATA_W'($urandom_range(0, 3000)));
                endcase
                cfg_write(IDX_ATTACK_COEF, draw_coef());
                cfg_write(IDX_RELEASE_COEF, draw_coef());
                cfg_write(IDX_ATTEN_GAIN, draw_gain());
                cfg_write(IDX_WET_MIX, draw_gain());
                cfg_write(IDX_STEREO_MODE, CFG_DATA_W'($urandom));
                if ($urandom_range(0, 3) == 0)
                    cfg_write($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
                              CFG_DATA_W'($urandom));
            end
        endcase
    endtask

    initial begin : stimulus
        t_level level;
        int     run_left;
        sb       = new();
        run_left = 0;
        level    = LEVEL_LOUD;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample_left  <= '0;
        in_ch.sample_right <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults straight after reset, sample extremes
        send_frame(16'h0000, 16'h0000);
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'hFFFF, 16'h0001);

        // envelope tracks the magnitude at once; threshold crossing both ways
        cfg_write(IDX_ATTACK_COEF, 17'd0);
        cfg_write(IDX_RELEASE_COEF, 17'd0);
        cfg_write(IDX_GATE_THRESHOLD, 17'd1000);
        cfg_write(IDX_ATTEN_GAIN, 17'd16384);
        cfg_write(IDX_WET_MIX, 17'd49152);
        send_frame(16'd999, -16'sd5);
        send_frame(-16'sd1000, 16'd3);
        send_frame(16'h8000, 16'h8000);
        send_frame(-16'sd7, 16'd12);
        send_frame(-16'sd3, -16'sd1);

        // gain registers above unity saturate
        cfg_write(IDX_ATTEN_GAIN, 17'h1FFFF);
        cfg_write(IDX_WET_MIX, 17'h1FFFF);
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'd12345, -16'sd12345);

        // mono, threshold beyond any magnitude, writes to spare indexes
        cfg_write(IDX_ATTEN_GAIN, 17'd30000);
        cfg_write(IDX_STEREO_MODE, 17'd0);
        cfg_write(IDX_GATE_THRESHOLD, 17'hFFFF);
        cfg_write(IDX_SPARE_LO, 17'h1FFFF);
        cfg_write(IDX_SPARE_HI, 17'h00000);
        send_frame(16'd100, 16'h8000);
        send_frame(16'h8000, 16'd5);
        send_frame(16'h7FFF, 16'h7FFF);

        for (int p = 0; p < PHASES; p++) begin
            load_settings(p == 0 ? SET_LOWS : (p == 1 ? SET_HIGHS : SET_RANDOM));
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                // runs of one signal level so the envelope rises and decays
                if (run_left == 0) begin
                    level    = t_level'($urandom_range(0, 3));
                    run_left = $urandom_range(1, 40);
                    in_burst = ($urandom_range(0, 3) == 0);
                end
                run_left--;
                send_frame(draw_sample(level), draw_sample(level));
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("Run: %0d frames (%0d mono, %0d gated), %0d register writes over %0d phases",
                 sb.frames, sb.mono_frames, sb.closed_frames, sb.reg_writes, PHASES + 4);
        $display("Checked %0d results, %0d mismatches", sb.results, sb.fails);
        if (sb.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
